[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files of the handle table.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication: post must hold whenever pre holds.
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication failed");
// Next-cycle implication: post must hold in the cycle after pre.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

[rtl/htnf_pkg.sv]
// Package for the next-fit handle table: request/response structs, opcodes,
// controller state type and controller/datapath command and status structs.
package htnf_pkg;

    localparam logic [1:0] MODE_INSTALL = 2'd0;
    localparam logic [1:0] MODE_LOOKUP  = 2'd1;
    localparam logic [1:0] MODE_CLOSE   = 2'd2;

    localparam logic [6:0] CFG_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  handle;
        logic [31:0] obj_ref;
        logic [31:0] rights_in;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [5:0]  slot_index;
        logic [31:0] obj_out;
        logic [31:0] rights_out;
        logic [6:0]  live_count;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_READ,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic search_init;
        logic search_step;
        logic install;
        logic mem_read;
        logic res_read;
        logic res_err;
    } t_cmd;

    typedef struct packed {
        logic is_install;
        logic is_access;
        logic hit;
        logic found;
        logic exhausted;
    } t_sts;

endpackage

[rtl/htnf_dp.sv]
// Datapath of the handle table: capacity register, used bits, slot memory,
// group-wise next-fit scan, live count, hint and response register. Uses htnf_pkg.
module htnf_dp #(
    parameter int SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  htnf_pkg::t_req    i_req,
    input  htnf_pkg::t_cmd    i_cmd,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_data,
    output htnf_pkg::t_sts    o_sts,
    output htnf_pkg::t_rsp    o_rsp
);
    localparam int IW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int GROUP = 8;
    localparam int GB    = $clog2(GROUP);
    localparam int NG    = (SLOTS + GROUP - 1) / GROUP;
    localparam int GW    = (NG > 1) ? $clog2(NG) : 1;

    logic [6:0]            r_cfg;
    htnf_pkg::t_req        r_req;
    logic [SLOTS-1:0]      r_used;
    logic [CW-1:0]         r_count;
    logic [IW-1:0]         r_hint;
    logic                  r_phase;
    logic [GW-1:0]         r_grp;
    logic [63:0]           r_mem [SLOTS];
    logic [63:0]           r_rdata;
    logic                  r_status;
    logic [5:0]            r_idx;
    logic [31:0]           r_obj;
    logic [31:0]           r_rights;

    logic [CW-1:0]         cap;
    logic                  hint_lt_cap;
    logic [CW-1:0]         lo;
    logic [CW-1:0]         hi;
    logic [NG*GROUP-1:0]   used_pad;
    logic [GROUP-1:0]      grp_bits;
    logic [GROUP-1:0]      cand;
    logic [GB-1:0]         pick;
    logic                  found;
    logic                  group_end;
    logic [IW-1:0]         slot;
    logic [IW-1:0]         hidx;
    logic                  hit;
    logic                  is_close;

    // saturate capacity to the table size
    always_comb begin
        cap = (32'(r_cfg) > 32'(SLOTS)) ? CW'(SLOTS) : CW'(r_cfg);
        hint_lt_cap = 32'(r_hint) < 32'(cap);
        lo = r_phase ? '0 : CW'(r_hint);
        hi = r_phase ? (hint_lt_cap ? CW'(r_hint) : cap) : cap;
    end

    // scan one group of slots per cycle
    always_comb begin
        used_pad = (NG*GROUP)'(r_used);
        grp_bits = used_pad[{r_grp, GB'(0)} +: GROUP];
        for (int k = 0; k < GROUP; k++) begin
            cand[k] = !grp_bits[k]
                      && (32'({r_grp, GB'(k)}) >= 32'(lo))
                      && (32'({r_grp, GB'(k)}) < 32'(hi));
        end
        pick = '0;
        for (int k = GROUP - 1; k >= 0; k--) begin
            if (cand[k]) begin
                pick = GB'(k);
            end
        end
        found = |cand;
        group_end = (32'({r_grp, {GB{1'b1}}}) + 32'd1) >= 32'(hi);
        slot = IW'({r_grp, pick});
    end

    always_comb begin
        hidx = IW'(r_req.handle);
        hit = (32'(r_req.handle) < 32'(cap)) && r_used[hidx];
        is_close = r_req.mode == htnf_pkg::MODE_CLOSE;
    end

    assign o_sts = '{
        is_install: r_req.mode == htnf_pkg::MODE_INSTALL,
        is_access:  (r_req.mode == htnf_pkg::MODE_LOOKUP) || is_close,
        hit:        hit,
        found:      found,
        exhausted:  !found && group_end && r_phase
    };

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= htnf_pkg::CFG_RESET;
            r_used  <= '0;
            r_count <= '0;
            r_hint  <= '0;
            r_phase <= 1'b0;
            r_grp   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.search_init) begin
                r_phase <= !hint_lt_cap;
                r_grp   <= hint_lt_cap ? GW'(r_hint >> GB) : '0;
            end else if (i_cmd.search_step && !found) begin
                if (group_end) begin
                    r_phase <= 1'b1;
                    r_grp   <= '0;
                end else begin
                    r_grp <= r_grp + GW'(1);
                end
            end
            if (i_cmd.install) begin
                r_used[slot] <= 1'b1;
                r_count      <= r_count + CW'(1);
                r_hint       <= ((32'(slot) + 32'd1) < 32'(cap)) ? IW'(32'(slot) + 32'd1) : '0;
            end
            if (i_cmd.res_read && is_close) begin
                r_used[hidx] <= 1'b0;
                if (r_count != '0) begin
                    r_count <= r_count - CW'(1);
                end
            end
        end
    end

    // request capture and response payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.install) begin
            r_status <= 1'b0;
            r_idx    <= 6'(slot);
            r_obj    <= '0;
            r_rights <= '0;
        end else if (i_cmd.res_read) begin
            r_status <= 1'b0;
            r_idx    <= r_req.handle;
            r_obj    <= r_rdata[63:32];
            r_rights <= is_close ? '0 : r_rdata[31:0];
        end else if (i_cmd.res_err) begin
            r_status <= 1'b1;
            r_idx    <= (r_req.mode == htnf_pkg::MODE_INSTALL) ? '0 : r_req.handle;
            r_obj    <= '0;
            r_rights <= '0;
        end
    end

    // slot memory: object in the upper word, rights in the lower
    always_ff @(posedge i_clk) begin
        if (i_cmd.install) begin
            r_mem[slot] <= {r_req.obj_ref, r_req.rights_in};
        end
        if (i_cmd.mem_read) begin
            r_rdata <= r_mem[hidx];
        end
    end

    assign o_rsp = '{
        status:     r_status,
        slot_index: r_idx,
        obj_out:    r_obj,
        rights_out: r_rights,
        live_count: 7'(r_count)
    };

endmodule

[rtl/htnf_ctrl.sv]
// Controller of the handle table: sequences decode, scan, memory read and
// response. Uses htnf_pkg for its state, command and status types.
module htnf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  htnf_pkg::t_sts    i_sts,
    output logic              busy,
    output htnf_pkg::t_cmd    o_cmd,
    output logic              o_rsp_valid
);
    htnf_pkg::t_state r_state;
    htnf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htnf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_rsp_valid = 1'b0;
        busy        = r_state != htnf_pkg::ST_IDLE;
        case (r_state)
            htnf_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = htnf_pkg::ST_DECODE;
                end
            end
            htnf_pkg::ST_DECODE: begin
                if (i_sts.is_install) begin
                    o_cmd.search_init = 1'b1;
                    n_state           = htnf_pkg::ST_SEARCH;
                end else if (i_sts.is_access && i_sts.hit) begin
                    o_cmd.mem_read = 1'b1;
                    n_state        = htnf_pkg::ST_READ;
                end else begin
                    o_cmd.res_err = 1'b1;
                    n_state       = htnf_pkg::ST_RESP;
                end
            end
            htnf_pkg::ST_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_sts.found) begin
                    o_cmd.install = 1'b1;
                    n_state       = htnf_pkg::ST_RESP;
                end else if (i_sts.exhausted) begin
                    o_cmd.res_err = 1'b1;
                    n_state       = htnf_pkg::ST_RESP;
                end
            end
            htnf_pkg::ST_READ: begin
                o_cmd.res_read = 1'b1;
                n_state        = htnf_pkg::ST_RESP;
            end
            htnf_pkg::ST_RESP: begin
                o_rsp_valid = 1'b1;
                n_state     = htnf_pkg::ST_IDLE;
            end
            default: begin
                n_state = htnf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/handle_table_next_fit_unit.sv]
// Top level of the next-fit handle table: controller plus datapath.
// Depends on htnf_pkg, htnf_ctrl, htnf_dp and assert_macros.svh.
//
// Usage:
//   Request channel: drive i_req and raise start; the request is taken at
//   a rising edge where start is high and busy is low. Modes are install,
//   lookup and close; any other mode answers with an error.
//   Response channel: o_rsp is valid for exactly one cycle, marked by
//   o_rsp_valid. The receiver cannot stall; it must take the response then.
//   Configuration: write the capacity through i_cfg_valid / o_cfg_ready /
//   i_cfg_data while idle; ready is high whenever not busy. Values above
//   SLOTS saturate to SLOTS.
// States (accept to next possible accept; the response strobe is given in
//   the respond state, which is followed by idle):
//   lookup or close on a used slot below the capacity: decode, read,
//   respond, idle. Error found at decode: decode, respond, idle.
//   install: decode, scan, respond, idle; the scan visits 8-slot groups, one
//   per cycle, from the hint to the capacity, then from zero to the hint.
// Reset: synchronous, active low; empties the table, clears the live count
//   and the hint, and sets the capacity to 64. Slot contents are not cleared.
module handle_table_next_fit_unit #(
    parameter int SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  htnf_pkg::t_req    i_req,
    output logic              o_rsp_valid,
    output htnf_pkg::t_rsp    o_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [6:0]        i_cfg_data
);
`include "assert_macros.svh"

    htnf_pkg::t_cmd cmd;
    htnf_pkg::t_sts sts;
    logic           cfg_we;

    // take capacity writes only between requests
    assign o_cfg_ready = !busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    htnf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_sts       (sts),
        .busy        (busy),
        .o_cmd       (cmd),
        .o_rsp_valid (o_rsp_valid)
    );

    htnf_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_rsp      (o_rsp)
    );

    // an accepted request holds the block busy in the next cycle
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // a response strobe lasts exactly one cycle
    `ASSERT_NEXT(a_rsp_single, i_clk, i_rst_n, o_rsp_valid, !o_rsp_valid)
    // a response belongs to a request still in flight
    `ASSERT_IMPLIES(a_rsp_in_busy, i_clk, i_rst_n, o_rsp_valid, busy)

endmodule

[tb/sv/htnf_table_checker.sv]
// Checker for the next-fit handle table: watches the request, response and
// capacity channels, predicts each response and compares it field by field.
// Depends on htnf_pkg for the request and response types and the opcodes.
module htnf_table_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  htnf_pkg::t_req i_req,
    input  logic           i_rsp_valid,
    input  htnf_pkg::t_rsp i_rsp,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  logic [6:0]     i_cfg_data,
    output int             o_mismatches,
    output int             o_outstanding
);

    localparam int NSLOT = 64;

    // shadow copy of the table
    logic [6:0]  cap_reg;
    bit          slot_used [NSLOT];
    logic [31:0] slot_obj [NSLOT];
    logic [31:0] slot_rights [NSLOT];
    int          live;
    int          hint;

    htnf_pkg::t_rsp rsp_due [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // Apply one request to the shadow table and return the response it earns.
    function automatic htnf_pkg::t_rsp table_op(htnf_pkg::t_req r);
        htnf_pkg::t_rsp y;
        int   lim;
        int   wrap_end;
        int   slot;
        int   i;
        bit   found;
        lim      = (cap_reg > NSLOT) ? NSLOT : int'(cap_reg);
        y.status     = 1'b1;
        y.slot_index = r.handle;
        y.obj_out    = '0;
        y.rights_out = '0;
        found        = 1'b0;
        slot         = 0;
        if (r.mode == htnf_pkg::MODE_INSTALL) begin
            y.slot_index = '0;
            wrap_end = (hint < lim) ? hint : lim;
            for (i = hint; i < lim && !found; i++) begin
                if (!slot_used[i]) begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            for (i = 0; i < wrap_end && !found; i++) begin
                if (!slot_used[i]) begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (found) begin
                slot_used[slot]   = 1'b1;
                slot_obj[slot]    = r.obj_ref;
                slot_rights[slot] = r.rights_in;
                live++;
                hint         = (slot + 1 < lim) ? slot + 1 : 0;
                y.status     = 1'b0;
                y.slot_index = 6'(slot);
            end
        end else if (r.mode == htnf_pkg::MODE_LOOKUP || r.mode == htnf_pkg::MODE_CLOSE) begin
            if (int'(r.handle) < lim && slot_used[r.handle]) begin
                y.status  = 1'b0;
                y.obj_out = slot_obj[r.handle];
                if (r.mode == htnf_pkg::MODE_LOOKUP) begin
                    y.rights_out = slot_rights[r.handle];
                end else begin
                    slot_used[r.handle]   = 1'b0;
                    slot_obj[r.handle]    = '0;
                    slot_rights[r.handle] = '0;
                    if (live > 0) live--;
                end
            end
        end
        y.live_count = 7'(live);
        return y;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            o_mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        htnf_pkg::t_rsp want;
        if (!i_rst_n) begin
            cap_reg = htnf_pkg::CFG_RESET;
            live    = 0;
            hint    = 0;
            for (int k = 0; k < NSLOT; k++) begin
                slot_used[k]   = 1'b0;
                slot_obj[k]    = '0;
                slot_rights[k] = '0;
            end
            rsp_due.delete();
        end else begin
            // compare first, then queue any request taken on this edge
            if (i_rsp_valid) begin
                if (rsp_due.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: response expected none actual %h", $time, i_rsp);
                end else begin
                    want = rsp_due.pop_front();
                    check_field("status", 32'(want.status), 32'(i_rsp.status));
                    check_field("slot_index", 32'(want.slot_index), 32'(i_rsp.slot_index));
                    check_field("obj_out", want.obj_out, i_rsp.obj_out);
                    check_field("rights_out", want.rights_out, i_rsp.rights_out);
                    check_field("live_count", 32'(want.live_count), 32'(i_rsp.live_count));
                end
            end
            if (i_start && !i_busy) rsp_due.push_back(table_op(i_req));
            if (i_cfg_valid && i_cfg_ready) cap_reg = i_cfg_data;
        end
        o_outstanding = rsp_due.size();
    end

endmodule

[tb/sv/handle_table_next_fit_unit_test.sv]
// Top of the next-fit handle table testbench: clock, reset, directed and
// random requests, capacity changes and the verdict.
// Depends on htnf_pkg, handle_table_next_fit_unit and htnf_table_checker.
module handle_table_next_fit_unit_test;

    // the one mode the block does not implement
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           start       = 1'b0;
    logic           busy;
    htnf_pkg::t_req i_req       = '0;
    logic           o_rsp_valid;
    htnf_pkg::t_rsp o_rsp;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [6:0]     i_cfg_data  = '0;

    int         mismatches;
    int         outstanding;

    // stimulus bookkeeping
    int          cur_cap = 64;
    int          n_sent = 0;
    int          n_cfg = 0;
    logic [63:0] live_mask;
    logic [1:0]  last_mode;

    handle_table_next_fit_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    htnf_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (i_req),
        .i_rsp_valid   (o_rsp_valid),
        .i_rsp         (o_rsp),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #1 i_clk = ~i_clk;

    // Track which handles hold objects, so that most lookups and closes
    // aim at live slots. Only one request is in flight, so the mode of the
    // last accepted request belongs to the next response.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            live_mask <= '0;
            last_mode <= htnf_pkg::MODE_INSTALL;
        end else begin
            if (start && !busy) last_mode <= i_req.mode;
            if (o_rsp_valid && !o_rsp.status) begin
                if (last_mode == htnf_pkg::MODE_INSTALL) begin
                    live_mask[o_rsp.slot_index] <= 1'b1;
                end else if (last_mode == htnf_pkg::MODE_CLOSE) begin
                    live_mask[o_rsp.slot_index] <= 1'b0;
                end
            end
        end
    end

    // Bound the run: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("handle_table_next_fit_unit: mismatch");
        $finish;
    end

    function automatic htnf_pkg::t_req mk_req(logic [1:0] m, logic [5:0] h, logic [31:0] o,
                                              logic [31:0] ri);
        htnf_pkg::t_req r;
        r.mode      = m;
        r.handle    = h;
        r.obj_ref   = o;
        r.rights_in = ri;
        return r;
    endfunction

    // Mostly random words, with the two extremes now and then.
    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'h0000_0000;
        if (r < 10) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Gap before the next request: mostly none or short, a few long.
    function automatic int next_gap(bit dense);
        int r;
        if (dense) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Prefer a live handle inside the capacity; otherwise any handle.
    function automatic logic [5:0] pick_handle();
        logic [5:0] h;
        int         hi;
        int         k;
        hi = (cur_cap == 0 || cur_cap > 64) ? 63 : cur_cap - 1;
        h  = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < 80) begin
            for (k = 0; k < 16; k++) begin
                h = 6'($urandom_range(0, hi));
                if (live_mask[h]) break;
            end
        end
        return h;
    endfunction

    // Present one request at a falling edge and hold it until taken. With a
    // zero gap start stays high so the next request follows back to back.
    task automatic send_request(htnf_pkg::t_req r, int gap);
        i_req <= r;
        start <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        n_sent++;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drop start, drain every response, then let the block settle.
    task automatic wait_idle();
        start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // Write the capacity register while the block is idle.
    task automatic set_capacity(logic [6:0] v);
        wait_idle();
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_cap = v;
        n_cfg++;
    endtask

    task automatic random_phase(logic [6:0] cap, int count);
        int             pinst;
        int             r;
        bit             dense;
        logic [1:0]     m;
        htnf_pkg::t_req q;
        set_capacity(cap);
        pinst = $urandom_range(30, 70);
        dense = ($urandom_range(0, 3) == 0);
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < pinst) begin
                q = mk_req(htnf_pkg::MODE_INSTALL, 6'($urandom), rand_word(), rand_word());
            end else if (r < 95) begin
                m = ($urandom_range(0, 99) < 60) ? htnf_pkg::MODE_LOOKUP
                                                  : htnf_pkg::MODE_CLOSE;
                q = mk_req(m, pick_handle(), rand_word(), rand_word());
            end else begin
                q = mk_req(MODE_SPARE, 6'($urandom), rand_word(), rand_word());
            end
            send_request(q, next_gap(dense));
        end
    endtask

    initial begin
        logic [6:0] caps [15];
        caps = '{7'd64, 7'd16, 7'd1, 7'd8, 7'd127, 7'd0, 7'd33, 7'd5,
                 7'd64, 7'd9, 7'd100, 7'd2, 7'd64, 7'd48, 7'd3};

        // hold reset low, then release it for good
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at full capacity: unused handles, field extremes,
        // the spare mode, close then lookup of the freed slot.
        set_capacity(7'd64);
        send_request(mk_req(htnf_pkg::MODE_LOOKUP, 6'd0, '0, '0), 0);
        send_request(mk_req(htnf_pkg::MODE_CLOSE, 6'd63, '1, '1), 1);
        send_request(mk_req(htnf_pkg::MODE_INSTALL, 6'd63, 32'h0000_0000, 32'hFFFF_FFFF), 0);
        send_request(mk_req(htnf_pkg::MODE_INSTALL, 6'd0, 32'hFFFF_FFFF, 32'h0000_0000), 2);
        send_request(mk_req(htnf_pkg::MODE_LOOKUP, 6'd0, '0, '0), 0);
        send_request(mk_req(htnf_pkg::MODE_LOOKUP, 6'd1, '1, '1), 0);
        send_request(mk_req(MODE_SPARE, 6'd63, '1, '1), 3);
        send_request(mk_req(htnf_pkg::MODE_CLOSE, 6'd0, '0, '0), 0);
        send_request(mk_req(htnf_pkg::MODE_LOOKUP, 6'd0, '0, '0), 0);
        send_request(mk_req(htnf_pkg::MODE_CLOSE, 6'd1, '0, '0), 1);
        // next fit: lands at the hint, not in the freed slots zero and one
        send_request(mk_req(htnf_pkg::MODE_INSTALL, 6'd0, 32'h1234_5678, 32'h8765_4321), 0);

        // Shrink to two: hint above the capacity, table full, a live slot
        // beyond the capacity that cannot be reached.
        set_capacity(7'd2);
        send_request(mk_req(htnf_pkg::MODE_INSTALL, 6'd0, 32'hA5A5_A5A5, 32'h5A5A_5A5A), 0);
        send_request(mk_req(htnf_pkg::MODE_INSTALL, 6'd0, 32'h0F0F_0F0F, 32'hF0F0_F0F0), 0);
        send_request(mk_req(htnf_pkg::MODE_INSTALL, 6'd0, '1, '1), 0);
        send_request(mk_req(htnf_pkg::MODE_LOOKUP, 6'd2, '0, '0), 2);
        send_request(mk_req(htnf_pkg::MODE_CLOSE, 6'd1, '0, '0), 0);
        send_request(mk_req(htnf_pkg::MODE_INSTALL, 6'd0, 32'hDEAD_0001, 32'h0000_0001), 0);

        // zero capacity: nothing fits and no handle is valid
        set_capacity(7'd0);
        send_request(mk_req(htnf_pkg::MODE_INSTALL, 6'd0, '1, '1), 0);
        send_request(mk_req(htnf_pkg::MODE_LOOKUP, 6'd0, '0, '0), 0);

        // grow again: the slot left beyond the old capacity comes back
        set_capacity(7'd127);
        send_request(mk_req(htnf_pkg::MODE_LOOKUP, 6'd2, '0, '0), 0);
        send_request(mk_req(htnf_pkg::MODE_CLOSE, 6'd2, '0, '0), 0);
        send_request(mk_req(htnf_pkg::MODE_CLOSE, 6'd0, '0, '0), 4);

        // Random part: one phase per capacity, each with its own mix.
        foreach (caps[p]) random_phase(caps[p], (caps[p] == 7'd0) ? 25 : 125);

        // drain, then allow the block to settle before the verdict
        wait_idle();
        repeat (20) @(negedge i_clk);

        $display("Covered %0d requests over %0d capacity writes (zero, one, 64, 127, between),",
                 n_sent, n_cfg);
        $display("with installs into full tables, stale handles and idle gaps of mixed length.");
        if (mismatches == 0) begin
            $display("handle_table_next_fit_unit: match");
        end else begin
            $display("handle_table_next_fit_unit: mismatch");
        end
        $finish;
    end

endmodule
